[rtl/tgarle_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel stream decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int unsigned BPP_W       = 3;
    localparam int unsigned COUNT_W     = 25;
    localparam int unsigned PIX_W       = 32;
    localparam int unsigned REP_W       = 8;
    localparam int unsigned ADDR_W      = 3;
    localparam int unsigned APB_W       = 32;
    localparam int unsigned MAX_PIXELS  = 16777216;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 25'd1;

    // register indexes (paddr[2])
    localparam logic REG_BPP   = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    // header split point and run bias
    localparam logic [7:0] RAW_LIMIT = 8'd128;
    localparam logic [7:0] RUN_BIAS  = 8'd127;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RAW,
        PH_RUN
    } t_phase;

    // one finished pixel handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [REP_W-1:0] count;
        logic             more;   // packet still has pixels after this one
    } t_token;

endpackage
`default_nettype wire

[rtl/tga_rle_decoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_decoder_core
// TGA run-length stream decoder: one compressed byte in, one pixel word out.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_data_byte
//   output    out        o_valid / i_stall    o_pixel_value, o_repeat_count,
//                                             o_last_pixel, o_overflow_error
//   config    in         psel/penable/pready  paddr, pwdata, prdata
//
// one byte accepted per cycle while o_stall is low; a finished pixel passes
// through a queue slot, then the output register.
// synchronous active-low reset returns the parser to header and the
// registers to 4 bytes per pixel and 1 pixel.
// o_stall rises only when the queue holds two pixels the output has not taken.
// ----------------------------------------------------------------------------
module tga_rle_decoder_core #(
    parameter int unsigned MAX_PIXELS = tgarle_pkg::MAX_PIXELS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire [7:0]                     i_data_byte,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [tgarle_pkg::PIX_W-1:0]  o_pixel_value,
    output logic [tgarle_pkg::REP_W-1:0]  o_repeat_count,
    output logic                          o_last_pixel,
    output logic                          o_overflow_error,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [tgarle_pkg::ADDR_W-1:0]  paddr,
    input  wire [tgarle_pkg::APB_W-1:0]   pwdata,
    output logic [tgarle_pkg::APB_W-1:0]  prdata,
    output logic                          pready
);
    import tgarle_pkg::*;

    logic [BPP_W-1:0]   r_bpp;
    logic [COUNT_W-1:0] r_count;
    logic [BPP_W-1:0]   bpp_eff;
    logic               wr_en;

    logic   push, pop, full, empty;
    t_token tok_in, tok_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp   <= BPP_RESET;
            r_count <= COUNT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_BPP:   r_bpp   <= pwdata[BPP_W-1:0];
                REG_COUNT: r_count <= pwdata[COUNT_W-1:0];
                default:   r_bpp   <= r_bpp;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BPP:   prdata = {{(APB_W-BPP_W){1'b0}}, r_bpp};
            REG_COUNT: prdata = {{(APB_W-COUNT_W){1'b0}}, r_count};
            default:   prdata = '0;
        endcase
    end

    // 0 reads as 1, 5..7 as 4
    always_comb begin
        bpp_eff = r_bpp;
        if (r_bpp == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (r_bpp > BPP_W'(4)) begin
            bpp_eff = BPP_W'(4);
        end
    end

    tgarle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_bpp       (bpp_eff),
        .i_full      (full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_token     (tok_in)
    );

    tgarle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (tok_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_token (tok_out)
    );

    tgarle_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_token          (tok_out),
        .i_pixel_count    (r_count),
        .i_stall          (i_stall),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_pixel_value    (o_pixel_value),
        .o_repeat_count   (o_repeat_count),
        .o_last_pixel     (o_last_pixel),
        .o_overflow_error (o_overflow_error)
    );

endmodule
`default_nettype wire

[rtl/tgarle_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_front
// Parses packet headers, gathers pixel bytes; one token per raw pixel or run.
// ----------------------------------------------------------------------------
module tgarle_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire [7:0]                    i_data_byte,
    input  wire [tgarle_pkg::BPP_W-1:0]  i_bpp,
    input  wire                          i_full,
    output logic                         o_stall,
    output logic                         o_push,
    output tgarle_pkg::t_token           o_token
);
    import tgarle_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_rem, n_rem;
    logic [1:0]  r_pos, n_pos;
    logic [31:0] r_gather, n_gather;

    logic        accept;
    logic        pix_done;
    logic [31:0] gather_new;
    logic [7:0]  take;
    logic [7:0]  rem_after;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;

    always_comb begin
        gather_new = r_gather;
        case (r_pos)
            2'd0:    gather_new[7:0]   = r_gather[7:0]   | i_data_byte;
            2'd1:    gather_new[15:8]  = r_gather[15:8]  | i_data_byte;
            2'd2:    gather_new[23:16] = r_gather[23:16] | i_data_byte;
            default: gather_new[31:24] = r_gather[31:24] | i_data_byte;
        endcase
    end

    assign pix_done  = ({1'b0, r_pos} + 3'd1) >= i_bpp;
    assign take      = (r_phase == PH_RAW) ? 8'd1 : r_rem;
    assign rem_after = (r_rem >= take) ? (r_rem - take) : 8'd0;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_phase = (i_data_byte < RAW_LIMIT) ? PH_RAW : PH_RUN;
                end
                PH_RAW, PH_RUN: begin
                    if (pix_done && rem_after == 8'd0) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: n_phase = PH_HEADER;
            endcase
        end
    end

    // datapath and token
    always_comb begin
        n_rem    = r_rem;
        n_pos    = r_pos;
        n_gather = r_gather;
        o_push   = 1'b0;
        o_token.value = gather_new;
        o_token.count = take;
        o_token.more  = (rem_after != 8'd0);
        if (accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_rem    = (i_data_byte < RAW_LIMIT) ? (i_data_byte + 8'd1)
                                                         : (i_data_byte - RUN_BIAS);
                    n_pos    = 2'd0;
                    n_gather = '0;
                end
                PH_RAW, PH_RUN: begin
                    if (pix_done) begin
                        o_push   = 1'b1;
                        n_rem    = rem_after;
                        n_pos    = 2'd0;
                        n_gather = '0;
                    end else begin
                        n_pos    = r_pos + 2'd1;
                        n_gather = gather_new;
                    end
                end
                default: begin
                    n_pos = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_rem    <= '0;
            r_pos    <= '0;
            r_gather <= '0;
        end else begin
            r_phase  <= n_phase;
            r_rem    <= n_rem;
            r_pos    <= n_pos;
            r_gather <= n_gather;
        end
    end

endmodule
`default_nettype wire

[rtl/tgarle_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_queue
// Two-entry token queue between the parsing front and the counting back.
// ----------------------------------------------------------------------------
module tgarle_queue (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  wire tgarle_pkg::t_token  i_token,
    input  wire                      i_pop,
    output logic                     o_full,
    output logic                     o_empty,
    output tgarle_pkg::t_token       o_token
);
    import tgarle_pkg::*;

    t_token     r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_token = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

[rtl/tgarle_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgarle_back
// Clips runs against the image size, tracks completion, holds the output word.
// ----------------------------------------------------------------------------
module tgarle_back #(
    parameter int unsigned MAX_PIXELS = tgarle_pkg::MAX_PIXELS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_empty,
    input  wire tgarle_pkg::t_token        i_token,
    input  wire [tgarle_pkg::COUNT_W-1:0]  i_pixel_count,
    input  wire                            i_stall,
    output logic                           o_pop,
    output logic                           o_valid,
    output logic [tgarle_pkg::PIX_W-1:0]   o_pixel_value,
    output logic [tgarle_pkg::REP_W-1:0]   o_repeat_count,
    output logic                           o_last_pixel,
    output logic                           o_overflow_error
);
    import tgarle_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_PIXELS);

    logic [COUNT_W-1:0] r_emitted;
    logic               r_finished;
    logic               r_valid;
    logic [PIX_W-1:0]   r_value;
    logic [REP_W-1:0]   r_rep;
    logic               r_last, r_err;

    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] avail;
    logic [COUNT_W-1:0] need;
    logic               clip, last;
    logic [REP_W-1:0]   n_out;
    logic               out_free, emit;

    always_comb begin
        count_eff = i_pixel_count;
        if (i_pixel_count == '0) begin
            count_eff = COUNT_W'(1);
        end else if (i_pixel_count > MAX_CNT) begin
            count_eff = MAX_CNT;
        end
    end

    assign avail = (count_eff > r_emitted) ? (count_eff - r_emitted) : '0;
    assign need  = {{(COUNT_W-REP_W){1'b0}}, i_token.count};
    assign clip  = need > avail;
    assign last  = need >= avail;
    assign n_out = clip ? avail[REP_W-1:0] : i_token.count;

    assign out_free = !r_valid || !i_stall;
    // tokens after completion are drained and dropped
    assign o_pop    = !i_empty && out_free;
    assign emit     = o_pop && !r_finished;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value <= i_token.value;
            r_rep   <= n_out;
            r_last  <= last;
            r_err   <= clip || (last && i_token.more);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_emitted  <= '0;
            r_finished <= 1'b0;
        end else begin
            if (out_free) begin
                r_valid <= emit;
            end
            if (emit) begin
                r_emitted <= r_emitted + {{(COUNT_W-REP_W){1'b0}}, n_out};
                if (last) begin
                    r_finished <= 1'b1;
                end
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_pixel_value    = r_value;
    assign o_repeat_count   = r_rep;
    assign o_last_pixel     = r_last;
    assign o_overflow_error = r_err;

endmodule
`default_nettype wire
